[sv/kinematic_state_frame_convert_unit_assert.svh]
// Assertion macros for the frame convert unit
`ifndef KINEMATIC_STATE_FRAME_CONVERT_UNIT_ASSERT_SVH
`define KINEMATIC_STATE_FRAME_CONVERT_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define KSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define KSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ksfc_pkg.sv]
`default_nettype none
package ksfc_pkg;
  localparam int QUAT_FRAC = 14;
  localparam int MAT_FRAC  = 28;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd5;
  localparam logic [63:0] QUAT_RESET = 64'h4000_0000_0000_0000;
  // Matrix entry: Q.28 with up to 2^6 magnitude
  typedef logic signed [34:0] mat_t;
endpackage
`default_nettype wire

[sv/kinematic_state_frame_convert_unit.sv]
// Kinematic frame convert: child-frame position, velocity and acceleration in,
// parent-frame values out, using configured rotation, translation, origin
// motion and angular rates.
// Input channel in_*: one transaction carries the nine child-frame components.
// Output channel out_*: one transaction carries nine parent-frame components
// and a saturation flag in out_tuser.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx; write only
// while the pipeline is empty. The rotation matrix is rebuilt from the
// quaternion register into a matrix register of its own after a write.
// Throughput: one transaction per cycle while the receiver accepts. The
// stages, in order, are the matrix-entry products, the row sums, the cross
// products, the start of the sums, the sums, and the rounding and clipping.
// Reset clears every valid bit and restores configuration register reset values.
// When the receiver stalls, the whole pipeline holds; in_tready follows
// out_tready whenever the last stage is full, so nothing is lost.
`default_nettype none
`include "kinematic_state_frame_convert_unit_assert.svh"
module kinematic_state_frame_convert_unit
  import ksfc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 21,
  parameter int FRAC_BITS = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, zero fill
  input  wire logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  wire logic out_tready,
  // out_pos_x..z, out_vel_x..z, out_acc_x..z, zero fill
  output logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic out_tuser,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int DW = ((9*CW+7)/8)*8;
  localparam int RW = CW + 3;            // rotated vector incl. clip range
  localparam int XW = 2*RW + 2;          // cross product width
  localparam int AW = 3*CW - FB + 4;     // acceleration sum width
  localparam int NST = 6;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [RW-1:0] rvec_t;
  typedef logic signed [XW-1:0] xp_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [63:0] prod_t;

  // Configuration registers
  logic [63:0] quat_r;
  logic [3*CW-1:0] trans_r, vel0_r, acc0_r, omega_r, alpha_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r <= QUAT_RESET;
      trans_r <= '0; vel0_r <= '0; acc0_r <= '0; omega_r <= '0; alpha_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_QUAT:  quat_r <= cfg_wdata;
        REG_TRANS: trans_r <= cfg_wdata[3*CW-1:0];
        REG_VEL0:  vel0_r <= cfg_wdata[3*CW-1:0];
        REG_ACC0:  acc0_r <= cfg_wdata[3*CW-1:0];
        REG_OMEGA: omega_r <= cfg_wdata[3*CW-1:0];
        REG_ALPHA: alpha_r <= cfg_wdata[3*CW-1:0];
        default: ;
      endcase
    end
  end

  function automatic comp_t vcomp(input logic [3*CW-1:0] r, input int i);
    vcomp = r[(2-i)*CW +: CW];
  endfunction

  // Build rotation matrix from quaternion (registered)
  logic signed [15:0] qw, qx, qy, qz;
  mat_t m_r [9];
  mat_t m_nxt [9];
  assign qw = quat_r[63:48];
  assign qx = quat_r[47:32];
  assign qy = quat_r[31:16];
  assign qz = quat_r[15:0];
  always_comb begin
    mat_t one;
    one = mat_t'(64'sd1 <<< MAT_FRAC);
    m_nxt[0] = one - 2*(mat_t'(qy*qy) + mat_t'(qz*qz));
    m_nxt[1] = 2*(mat_t'(qx*qy) - mat_t'(qw*qz));
    m_nxt[2] = 2*(mat_t'(qx*qz) + mat_t'(qw*qy));
    m_nxt[3] = 2*(mat_t'(qx*qy) + mat_t'(qw*qz));
    m_nxt[4] = one - 2*(mat_t'(qx*qx) + mat_t'(qz*qz));
    m_nxt[5] = 2*(mat_t'(qy*qz) - mat_t'(qw*qx));
    m_nxt[6] = 2*(mat_t'(qx*qz) - mat_t'(qw*qy));
    m_nxt[7] = 2*(mat_t'(qy*qz) + mat_t'(qw*qx));
    m_nxt[8] = one - 2*(mat_t'(qx*qx) + mat_t'(qy*qy));
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) m_r[k] <= m_nxt[k];
  end

  // Pipeline control: global enable, stall when last stage full and blocked
  logic [NST-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[NST-1] || out_tready;
  assign in_tready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  // Stage 1: products matrix entry times component
  prod_t s1_p_r [3][9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 3; v++)
        for (int k = 0; k < 9; k++)
          s1_p_r[v][k] <= prod_t'(m_r[k]) *
                          prod_t'($signed(in_tdata[(3*v + k%3)*CW +: CW]));
    end
  end

  // Stage 2: row sums, round and clip
  function automatic rvec_t rnd_clip(input prod_t s);
    prod_t t, lim;
    t = (s + (64'sd1 <<< (MAT_FRAC-1))) >>> MAT_FRAC;
    lim = 64'sd1 <<< (CW+1);
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    rnd_clip = rvec_t'(t);
  endfunction
  rvec_t s2_r [3][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 3; v++)
        for (int i = 0; i < 3; i++)
          s2_r[v][i] <= rnd_clip(s1_p_r[v][3*i] + s1_p_r[v][3*i+1] + s1_p_r[v][3*i+2]);
    end
  end

  // Stage 3: cross products W x rp, AL x rp, W x rv
  function automatic xp_t xc(input rvec_t a0, a1, b0, b1);
    xc = xp_t'(a0*b1) - xp_t'(a1*b0);
  endfunction
  function automatic rvec_t wc(input logic [3*CW-1:0] r, input int i);
    wc = rvec_t'(vcomp(r, i));
  endfunction
  xp_t s3_c1_r [3], s3_c2_r [3], s3_c4_r [3];
  rvec_t s3_rp_r [3], s3_rv_r [3], s3_ra_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_c1_r[i] <= xc(wc(omega_r,(i+1)%3), wc(omega_r,(i+2)%3),
                         s2_r[0][(i+1)%3], s2_r[0][(i+2)%3]);
        s3_c2_r[i] <= xc(wc(alpha_r,(i+1)%3), wc(alpha_r,(i+2)%3),
                         s2_r[0][(i+1)%3], s2_r[0][(i+2)%3]);
        s3_c4_r[i] <= xc(wc(omega_r,(i+1)%3), wc(omega_r,(i+2)%3),
                         s2_r[1][(i+1)%3], s2_r[1][(i+2)%3]);
        s3_rp_r[i] <= s2_r[0][i];
        s3_rv_r[i] <= s2_r[1][i];
        s3_ra_r[i] <= s2_r[2][i];
      end
    end
  end

  // Stage 4: round W x rp to get u; start sums
  typedef logic signed [XW-FB:0] u_t;
  u_t s4_u_r [3];
  acc_t s4_acc_r [3];
  rvec_t s4_rp_r [3], s4_rv_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_u_r[i] <= u_t'((s3_c1_r[i] + (xp_t'(1) <<< (FB-1))) >>> FB);
        s4_acc_r[i] <= ((acc_t'(s3_ra_r[i]) + acc_t'(vcomp(acc0_r, i))) <<< FB)
                       + acc_t'(s3_c2_r[i]) + (acc_t'(s3_c4_r[i]) <<< 1);
        s4_rp_r[i] <= s3_rp_r[i];
        s4_rv_r[i] <= s3_rv_r[i];
      end
    end
  end

  // Stage 5: W x u, position and velocity sums
  acc_t s5_acc_r [3];
  acc_t s5_pos_r [3], s5_vel_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_acc_r[i] <= s4_acc_r[i]
          + acc_t'(vcomp(omega_r,(i+1)%3) * s4_u_r[(i+2)%3])
          - acc_t'(vcomp(omega_r,(i+2)%3) * s4_u_r[(i+1)%3]);
        s5_pos_r[i] <= acc_t'(s4_rp_r[i]) + acc_t'(vcomp(trans_r, i));
        s5_vel_r[i] <= acc_t'(s4_rv_r[i]) + acc_t'(s4_u_r[i]) + acc_t'(vcomp(vel0_r, i));
      end
    end
  end

  // Stage 6: round acceleration, clip everything
  function automatic logic [CW:0] sat_c(input acc_t x);
    acc_t hi, lo;
    hi = (acc_t'(1) <<< (CW-1)) - 1;
    lo = -(acc_t'(1) <<< (CW-1));
    if (x > hi) sat_c = {1'b1, hi[CW-1:0]};
    else if (x < lo) sat_c = {1'b1, lo[CW-1:0]};
    else sat_c = {1'b0, x[CW-1:0]};
  endfunction
  logic [DW-1:0] out_data_r;
  logic out_sat_r;
  always_ff @(posedge clk) begin
    logic [CW:0] c;
    logic s;
    logic [DW-1:0] d;
    if (adv) begin
      s = 1'b0;
      d = '0;
      for (int i = 0; i < 3; i++) begin
        c = sat_c(s5_pos_r[i]); s |= c[CW]; d[i*CW +: CW] = c[CW-1:0];
        c = sat_c(s5_vel_r[i]); s |= c[CW]; d[(3+i)*CW +: CW] = c[CW-1:0];
        c = sat_c((s5_acc_r[i] + (acc_t'(1) <<< (FB-1))) >>> FB);
        s |= c[CW]; d[(6+i)*CW +: CW] = c[CW-1:0];
      end
      out_data_r <= d;
      out_sat_r <= s;
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata = out_data_r;
  assign out_tuser = out_sat_r;

  `KSF_ASSERT_IMP(a_ready_when_empty, !vld_r[NST-1], in_tready, "pipeline blocked while empty")
  `KSF_ASSERT_NXT(a_hold_on_stall, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                  "output changed under stall")
  `KSF_ASSERT_NXT(a_flow, in_tready && (vld_r == '0) && !in_tvalid, !vld_r[0],
                  "bubble became valid")
endmodule
`default_nettype wire
